// ----- hdl/chbd_pkg.sv -----
// Shared types, constants and helpers for the chunked body decoder.
// No dependencies; every other file refers to it by scoped names.
package chbd_pkg;

    localparam int unsigned SIZE_DIGITS_MAX = 8;
    localparam int unsigned DIGIT_CNT_W     = $clog2(SIZE_DIGITS_MAX + 1);
    localparam int unsigned COUNT_W         = 32;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned STATUS_W        = 2;
    localparam int unsigned CFG_ADDR_W      = 1;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_BODY_BYTES     = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_CHECK_ENABLE = 1'd1;

    localparam logic [COUNT_W-1:0] MAX_BODY_BYTES_RST = 32'd1048576;

    typedef enum logic [3:0] {
        PH_SIZE,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_LAST_CR,
        PH_LAST_LF,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_PAYLOAD   = 2'd0,
        ST_COMPLETE  = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_MALFORMED = 2'd3
    } t_status;

    typedef struct packed {
        logic                valid;
        logic [BYTE_W-1:0]   data;
        t_status             status;
        logic [COUNT_W-1:0]  length;
    } t_result;

    typedef struct packed {
        logic                is_hex;
        logic [3:0]          value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [BYTE_W-1:0] c);
        t_hex r;
        r.is_hex = 1'b1;
        r.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.value = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.value = 4'(c - 8'h61 + 8'd10);
        end else begin
            r.is_hex = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- hdl/chbd_parser.sv -----
// Parser state registers and the per-item next-state and result logic.
// Depends on chbd_pkg.
module chbd_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [chbd_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_start,
    input  logic [chbd_pkg::COUNT_W-1:0]  i_max_body_bytes,
    input  logic                          i_limit_en,
    output chbd_pkg::t_result             o_result
);

    chbd_pkg::t_phase                       r_phase, n_phase, cur_phase;
    logic [chbd_pkg::COUNT_W-1:0]           r_remain, n_remain, cur_remain;
    logic [chbd_pkg::COUNT_W-1:0]           r_count, n_count, cur_count;
    logic [chbd_pkg::DIGIT_CNT_W-1:0]       r_digits, n_digits, cur_digits;
    chbd_pkg::t_hex                         hex;
    logic [chbd_pkg::COUNT_W-1:0]           remain_dec;
    logic [chbd_pkg::COUNT_W-1:0]           count_inc;

    always_comb begin
        if (i_start) begin
            cur_phase  = chbd_pkg::PH_SIZE;
            cur_remain = '0;
            cur_count  = '0;
            cur_digits = '0;
        end else begin
            cur_phase  = r_phase;
            cur_remain = r_remain;
            cur_count  = r_count;
            cur_digits = r_digits;
        end
    end

    assign hex        = chbd_pkg::hex_decode(i_byte);
    assign remain_dec = cur_remain - 1'b1;
    assign count_inc  = (&cur_count) ? cur_count : cur_count + 1'b1;

    // next state
    always_comb begin
        n_phase  = cur_phase;
        n_remain = cur_remain;
        n_count  = cur_count;
        n_digits = cur_digits;
        unique case (cur_phase)
            chbd_pkg::PH_SIZE: begin
                if (i_byte == chbd_pkg::CHAR_CR) begin
                    n_phase = chbd_pkg::PH_SIZE_LF;
                end else if (hex.is_hex) begin
                    if (cur_digits >= chbd_pkg::DIGIT_CNT_W'(chbd_pkg::SIZE_DIGITS_MAX)) begin
                        n_phase = chbd_pkg::PH_ERROR;
                    end else begin
                        n_digits = cur_digits + 1'b1;
                        n_remain = {cur_remain[chbd_pkg::COUNT_W-5:0], hex.value};
                    end
                end
            end
            chbd_pkg::PH_SIZE_LF: begin
                if (i_byte != chbd_pkg::CHAR_LF) begin
                    n_phase = chbd_pkg::PH_ERROR;
                end else begin
                    n_digits = '0;
                    n_phase  = (cur_remain == '0) ? chbd_pkg::PH_LAST_CR : chbd_pkg::PH_DATA;
                end
            end
            chbd_pkg::PH_DATA: begin
                n_count  = count_inc;
                n_remain = remain_dec;
                if (i_limit_en && count_inc > i_max_body_bytes) begin
                    n_phase = chbd_pkg::PH_ERROR;
                end else if (remain_dec == '0) begin
                    n_phase = chbd_pkg::PH_DATA_CR;
                end
            end
            chbd_pkg::PH_DATA_CR: begin
                n_phase = (i_byte == chbd_pkg::CHAR_CR) ? chbd_pkg::PH_DATA_LF
                                                        : chbd_pkg::PH_ERROR;
            end
            chbd_pkg::PH_DATA_LF: begin
                if (i_byte != chbd_pkg::CHAR_LF) begin
                    n_phase = chbd_pkg::PH_ERROR;
                end else begin
                    n_phase  = chbd_pkg::PH_SIZE;
                    n_remain = '0;
                    n_digits = '0;
                end
            end
            chbd_pkg::PH_LAST_CR: begin
                n_phase = (i_byte == chbd_pkg::CHAR_CR) ? chbd_pkg::PH_LAST_LF
                                                        : chbd_pkg::PH_ERROR;
            end
            chbd_pkg::PH_LAST_LF: begin
                n_phase = (i_byte == chbd_pkg::CHAR_LF) ? chbd_pkg::PH_DONE
                                                        : chbd_pkg::PH_ERROR;
            end
            default: begin
            end
        endcase
    end

    // result
    always_comb begin
        o_result.valid  = 1'b0;
        o_result.data   = '0;
        o_result.status = chbd_pkg::ST_MALFORMED;
        o_result.length = cur_count;
        unique case (cur_phase)
            chbd_pkg::PH_SIZE: begin
                o_result.valid = (i_byte != chbd_pkg::CHAR_CR) && hex.is_hex &&
                    (cur_digits >= chbd_pkg::DIGIT_CNT_W'(chbd_pkg::SIZE_DIGITS_MAX));
            end
            chbd_pkg::PH_SIZE_LF, chbd_pkg::PH_DATA_LF, chbd_pkg::PH_LAST_CR: begin
                o_result.valid = (i_byte != chbd_pkg::CHAR_LF) ||
                                 (cur_phase == chbd_pkg::PH_LAST_CR);
                if (cur_phase == chbd_pkg::PH_LAST_CR) begin
                    o_result.valid = (i_byte != chbd_pkg::CHAR_CR);
                end
            end
            chbd_pkg::PH_DATA_CR: begin
                o_result.valid = (i_byte != chbd_pkg::CHAR_CR);
            end
            chbd_pkg::PH_DATA: begin
                o_result.valid  = 1'b1;
                o_result.length = count_inc;
                if (i_limit_en && count_inc > i_max_body_bytes) begin
                    o_result.status = chbd_pkg::ST_TOO_LARGE;
                end else begin
                    o_result.status = chbd_pkg::ST_PAYLOAD;
                    o_result.data   = i_byte;
                end
            end
            chbd_pkg::PH_LAST_LF: begin
                o_result.valid = 1'b1;
                if (i_byte == chbd_pkg::CHAR_LF) begin
                    o_result.status = chbd_pkg::ST_COMPLETE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= chbd_pkg::PH_SIZE;
            r_remain <= '0;
            r_count  <= '0;
            r_digits <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_count  <= n_count;
            r_digits <= n_digits;
        end
    end

endmodule

// ----- hdl/chbd_out_reg.sv -----
// Result register on the master side, loaded by the parser and drained by tready.
// Depends on chbd_pkg.
module chbd_out_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  chbd_pkg::t_result             i_result,
    input  logic                          i_ready,
    output logic                          o_free,
    output logic                          o_valid,
    output logic [chbd_pkg::BYTE_W-1:0]   o_data,
    output logic [chbd_pkg::STATUS_W-1:0] o_status,
    output logic [chbd_pkg::COUNT_W-1:0]  o_length
);

    logic r_valid;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_result.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            o_data   <= i_result.data;
            o_status <= i_result.status;
            o_length <= i_result.length;
        end
    end

endmodule

// ----- hdl/http_chunked_body_decoder_core.sv -----
// Top level of the chunked body decoder: input register, config registers,
// parser and result register. Depends on chbd_pkg, chbd_parser, chbd_out_reg.
//
// Usage:
//   Slave channel carries one raw body byte per item in s_axis_tdata; the
//   tuser bit marks the first byte of a new body and clears the parser.
//   Master channel gives zero or one item per input byte: a payload byte,
//   body complete, too large or malformed, with the running decoded length.
//   An accepted byte passes from the input register through the combinational
//   parser into the result register. Throughput is one byte per cycle while the
//   result register is free; a byte that yields no result still takes its slot
//   through the parser, which steps once per cycle from its state registers.
//   Config writes via i_cfg_we/i_cfg_addr/i_cfg_wdata take effect at once and
//   belong in idle periods. Reset loads a limit of 1 MiB with the check on and
//   returns the parser to awaiting a size line.
//   When the receiver stalls, the result register holds and one more byte
//   waits in the input register; s_axis_tready then drops.
module http_chunked_body_decoder_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // data_byte
    input  logic [0:0]                       s_axis_tuser,  // body_start
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [39:0]                      m_axis_tdata,  // payload_byte, body_length
    output logic [1:0]                       m_axis_tuser,  // status
    input  logic                             i_cfg_we,
    input  logic [chbd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [chbd_pkg::COUNT_W-1:0]     i_cfg_wdata
);

    logic                          r_in_valid;
    logic [chbd_pkg::BYTE_W-1:0]   r_in_byte;
    logic                          r_in_start;
    logic [chbd_pkg::COUNT_W-1:0]  r_max_body_bytes;
    logic                          r_limit_en;
    logic                          out_free;
    logic                          advance;
    chbd_pkg::t_result             result;

    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body_bytes <= chbd_pkg::MAX_BODY_BYTES_RST;
            r_limit_en       <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                chbd_pkg::REG_MAX_BODY_BYTES:     r_max_body_bytes <= i_cfg_wdata;
                chbd_pkg::REG_LIMIT_CHECK_ENABLE: r_limit_en       <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    chbd_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_byte           (r_in_byte),
        .i_start          (r_in_start),
        .i_max_body_bytes (r_max_body_bytes),
        .i_limit_en       (r_limit_en),
        .o_result         (result)
    );

    chbd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (result),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_data   (m_axis_tdata[7:0]),
        .o_status (m_axis_tuser),
        .o_length (m_axis_tdata[39:8])
    );

endmodule

// ----- hdl/chbd_checker.sv -----
// Port-level checks for the chunked body decoder, bound to the top level.
// Depends on chbd_pkg and http_chunked_body_decoder_core.
module chbd_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,
    input  logic [0:0]                       s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [39:0]                      m_axis_tdata,
    input  logic [1:0]                       m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [chbd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [chbd_pkg::COUNT_W-1:0]     i_cfg_wdata
);

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_status_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != chbd_pkg::ST_PAYLOAD |-> m_axis_tdata[7:0] == 8'd0)
        else $error("nonzero byte on a status item");

    a_payload_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == chbd_pkg::ST_PAYLOAD |-> m_axis_tdata[39:8] != 32'd0)
        else $error("payload item with zero length");

endmodule

bind http_chunked_body_decoder_core chbd_checker u_chbd_checker (.*);
